// ===== hdl/ckoc_pkg.sv =====
// shared types, constants and helpers for the color key overlay compositor
// used by every module in hdl/, depends on nothing
`default_nettype none

package ckoc_pkg;

    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 11;
    localparam int PIX_W      = 8;
    localparam int LUMA_IDX_W = 22;
    localparam int CHR_IDX_W  = 21;
    localparam int PROD_W     = 23;
    localparam int LORIG_W    = 24;
    localparam int CMP_W      = 16;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERLAY_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY            = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MODE    = 3'd7;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH    = 12'd352;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT   = 12'd288;
    localparam logic [POS_W-1:0] RST_POS_X          = 11'd0;
    localparam logic [POS_W-1:0] RST_POS_Y          = 11'd0;
    localparam logic [CFG_W-1:0] RST_OVERLAY_WIDTH  = 12'd2;
    localparam logic [CFG_W-1:0] RST_OVERLAY_HEIGHT = 12'd1;
    localparam logic [PIX_W-1:0] RST_KEY            = 8'd0;
    localparam logic             RST_CHROMA_MODE    = 1'b0;

    typedef logic [PIX_W-1:0] pixel_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic                  write_top;
        logic                  write_below;
        logic                  last;
        logic                  mode;
        logic [PROD_W-1:0]     prod;       // pos_y rounded down to even, times clamped frame width
        logic [POS_W-2:0]      px_half;    // pos_x / 2
        logic [LUMA_IDX_W-1:0] luma_ofs;   // row base plus column
        logic [CHR_IDX_W-1:0]  chroma_ofs;
        pixel_t                luma_left;
        pixel_t                chroma_u;
        pixel_t                luma_right;
        pixel_t                chroma_v;
        pixel_t                luma_left_below;
        pixel_t                luma_right_below;
    } cmd_t;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int lim);
        logic [CMP_W-1:0] wide;
        logic [CMP_W-1:0] lim_w;
        wide  = CMP_W'(v);
        lim_w = CMP_W'(lim);
        return (wide > lim_w) ? CFG_W'(lim) : v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/color_key_overlay_compositor.sv =====
// color keyed overlay compositor for planar YUV 4:2:2 / 4:2:0 frames
// depends on ckoc_pkg, ckoc_front, ckoc_queue, ckoc_back
//
// Usage: program the eight registers over the cfg_* write port while the block
// is idle (index 0 frame_width .. index 7 chroma_mode), then stream the overlay
// in raster order on s_*, one horizontal pixel pair per item. In 4:2:0 mode an
// item also carries the pair one overlay row below and items cover every other
// overlay row. Each accepted item produces exactly one frame write command on
// m_*: write flags in m_tuser, luma and chroma indices plus pixel data in
// m_tdata, and m_tlast on the final pair of the overlay.
// An accepted item is registered first in the queue (front classifies and
// multiplies into it) and then in the output register that drives m_tvalid
// (back adds indices).
// Throughput: one item per cycle while the queue is not full, since every
// stage is a single pass of counters, compares, one multiply and an add.
// When m_tready is low the output register holds its result and the two entry
// queue keeps taking items; s_tready drops only once the queue is full.
// Reset (aresetn low, synchronous) restores register defaults (352x288 frame,
// 2x1 overlay at 0,0, key 0, 4:2:2) and restarts the overlay counters.
`default_nettype none

module color_key_overlay_compositor #(
    parameter int MAX_WIDTH  = ckoc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ckoc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ckoc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [ckoc_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // luma_left, chroma_u, luma_right, chroma_v, luma_left_below, luma_right_below
    input  wire logic [ckoc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // luma_index, chroma_index, out_luma_left, out_luma_right, out_u, out_v,
    // out_luma_left_below, out_luma_right_below, zero fill
    output logic [ckoc_pkg::M_TDATA_W-1:0]       m_tdata,
    // write_top, write_below
    output logic [ckoc_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tlast
);

    logic           q_ready, q_push, q_valid, q_pop;
    ckoc_pkg::cmd_t q_in, q_out;

    ckoc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    ckoc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    ckoc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/ckoc_front.sv =====
// front part: configuration registers, overlay counters and item classification
// depends on ckoc_pkg
`default_nettype none

module ckoc_front #(
    parameter int MAX_WIDTH  = ckoc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ckoc_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ckoc_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [ckoc_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ckoc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            q_ready,
    output logic                                 q_push,
    output ckoc_pkg::cmd_t                       q_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ckoc_pkg::CMP_W;

    logic [ckoc_pkg::CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [ckoc_pkg::CFG_W-1:0] overlay_width_reg, overlay_height_reg;
    logic [ckoc_pkg::POS_W-1:0] pos_x_reg, pos_y_reg;
    ckoc_pkg::pixel_t            key_reg;
    logic                        mode_reg;

    logic [CW-2:0]                     column_reg, column_next;
    logic [RW-1:0]                     row_reg, row_next;
    logic [ckoc_pkg::LUMA_IDX_W-1:0]   luma_base_reg, luma_base_next;
    logic [ckoc_pkg::CHR_IDX_W-1:0]    chroma_base_reg, chroma_base_next;

    logic [ckoc_pkg::CFG_W-1:0] fw, fh, ow, oh;
    logic [ckoc_pkg::POS_W-1:0] px, py;
    logic [CW-1:0]              col;
    logic [CMP_W-1:0]           fx, fy, row_w, step_w;
    logic                       top, below, row_end, last, accept;
    ckoc_pkg::pixel_t           yl, u, yr, v, ylb, yrb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg    <= ckoc_pkg::RST_FRAME_WIDTH;
            frame_height_reg   <= ckoc_pkg::RST_FRAME_HEIGHT;
            pos_x_reg          <= ckoc_pkg::RST_POS_X;
            pos_y_reg          <= ckoc_pkg::RST_POS_Y;
            overlay_width_reg  <= ckoc_pkg::RST_OVERLAY_WIDTH;
            overlay_height_reg <= ckoc_pkg::RST_OVERLAY_HEIGHT;
            key_reg            <= ckoc_pkg::RST_KEY;
            mode_reg           <= ckoc_pkg::RST_CHROMA_MODE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ckoc_pkg::REG_FRAME_WIDTH:    frame_width_reg    <= cfg_wdata;
                ckoc_pkg::REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_wdata;
                ckoc_pkg::REG_POS_X:          pos_x_reg          <= cfg_wdata[ckoc_pkg::POS_W-1:0];
                ckoc_pkg::REG_POS_Y:          pos_y_reg          <= cfg_wdata[ckoc_pkg::POS_W-1:0];
                ckoc_pkg::REG_OVERLAY_WIDTH:  overlay_width_reg  <= cfg_wdata;
                ckoc_pkg::REG_OVERLAY_HEIGHT: overlay_height_reg <= cfg_wdata;
                ckoc_pkg::REG_KEY:            key_reg            <= cfg_wdata[ckoc_pkg::PIX_W-1:0];
                ckoc_pkg::REG_CHROMA_MODE:    mode_reg           <= cfg_wdata[0];
            endcase
        end
    end

    assign yl  = s_tdata[7:0];
    assign u   = s_tdata[15:8];
    assign yr  = s_tdata[23:16];
    assign v   = s_tdata[31:24];
    assign ylb = s_tdata[39:32];
    assign yrb = s_tdata[47:40];

    always_comb begin
        fw = ckoc_pkg::clamp_dim(frame_width_reg, MAX_WIDTH);
        fh = ckoc_pkg::clamp_dim(frame_height_reg, MAX_HEIGHT);
        ow = ckoc_pkg::clamp_dim(overlay_width_reg, MAX_WIDTH);
        oh = ckoc_pkg::clamp_dim(overlay_height_reg, MAX_HEIGHT);
        px = {pos_x_reg[ckoc_pkg::POS_W-1:1], 1'b0};
        py = {pos_y_reg[ckoc_pkg::POS_W-1:1], 1'b0};

        col    = {column_reg, 1'b0};
        row_w  = CMP_W'(row_reg);
        step_w = mode_reg ? CMP_W'(2) : CMP_W'(1);
        fx     = CMP_W'(px) + CMP_W'(col);
        fy     = CMP_W'(py) + row_w;

        top = (fx + CMP_W'(1) < CMP_W'(fw)) && (fy < CMP_W'(fh)) && (yl != key_reg);
        below = mode_reg && top && (fy + CMP_W'(1) < CMP_W'(fh))
                && (row_w + CMP_W'(1) < CMP_W'(oh));
        row_end = (CMP_W'(col) + CMP_W'(2) >= CMP_W'(ow));
        last    = row_end && (row_w + step_w >= CMP_W'(oh));

        column_next      = column_reg;
        row_next         = row_reg;
        luma_base_next   = luma_base_reg;
        chroma_base_next = chroma_base_reg;
        if (!row_end) begin
            column_next = column_reg + 1'b1;
        end else if (last) begin
            column_next      = '0;
            row_next         = '0;
            luma_base_next   = '0;
            chroma_base_next = '0;
        end else begin
            column_next      = '0;
            row_next         = RW'(row_w + step_w);
            luma_base_next   = luma_base_reg + (mode_reg ? ckoc_pkg::LUMA_IDX_W'({fw, 1'b0})
                                                         : ckoc_pkg::LUMA_IDX_W'(fw));
            chroma_base_next = chroma_base_reg + ckoc_pkg::CHR_IDX_W'(fw[ckoc_pkg::CFG_W-1:1]);
        end
    end

    assign accept   = s_tvalid && q_ready;
    assign s_tready = q_ready;
    assign q_push   = accept;

    always_comb begin
        q_data.write_top        = top;
        q_data.write_below      = below;
        q_data.last             = last;
        q_data.mode             = mode_reg;
        q_data.prod             = ckoc_pkg::PROD_W'(py) * ckoc_pkg::PROD_W'(fw);
        q_data.px_half          = px[ckoc_pkg::POS_W-1:1];
        q_data.luma_ofs         = luma_base_reg + ckoc_pkg::LUMA_IDX_W'(col);
        q_data.chroma_ofs       = chroma_base_reg + ckoc_pkg::CHR_IDX_W'(column_reg);
        q_data.luma_left        = yl;
        q_data.chroma_u         = u;
        q_data.luma_right       = yr;
        q_data.chroma_v         = v;
        q_data.luma_left_below  = ylb;
        q_data.luma_right_below = yrb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg      <= '0;
            row_reg         <= '0;
            luma_base_reg   <= '0;
            chroma_base_reg <= '0;
        end else if (accept) begin
            column_reg      <= column_next;
            row_reg         <= row_next;
            luma_base_reg   <= luma_base_next;
            chroma_base_reg <= chroma_base_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ckoc_queue.sv =====
// short queue of classified items between front and back
// depends on ckoc_pkg
`default_nettype none

module ckoc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire ckoc_pkg::cmd_t  push_data,
    output logic                 not_full,
    input  wire logic            pop,
    output logic                 not_empty,
    output ckoc_pkg::cmd_t       pop_data
);

    localparam int DEPTH = ckoc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    ckoc_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign not_full  = (count_reg != NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !not_full |-> pop)
        else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== hdl/ckoc_back.sv =====
// back part: final luma and chroma index sums and the output register
// depends on ckoc_pkg
`default_nettype none

module ckoc_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    input  wire ckoc_pkg::cmd_t                  q_data,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ckoc_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [ckoc_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                 m_tlast
);

    localparam int LW = ckoc_pkg::LORIG_W;

    logic                                 valid_reg;
    logic [ckoc_pkg::M_TDATA_W-1:0]       data_reg, data_next;
    logic [ckoc_pkg::M_TUSER_W-1:0]       user_reg, user_next;
    logic                                 last_reg;

    logic [LW-1:0]                        lorig, corig;
    logic [ckoc_pkg::LUMA_IDX_W-1:0]      lidx;
    logic [ckoc_pkg::CHR_IDX_W-1:0]       cidx;
    ckoc_pkg::pixel_t                     yl, yr, u, v, ylb, yrb;
    logic                                 load;

    assign load  = q_valid && (!valid_reg || m_tready);
    assign q_pop = load;

    always_comb begin
        lorig = LW'(q_data.prod) + LW'(q_data.px_half) + LW'(q_data.px_half);
        // 4:2:0 chroma plane is a quarter of the luma plane
        corig = q_data.mode ? (LW'(q_data.prod >> 2) + LW'(q_data.px_half)) : (lorig >> 1);
        lidx  = lorig[ckoc_pkg::LUMA_IDX_W-1:0] + q_data.luma_ofs;
        cidx  = corig[ckoc_pkg::CHR_IDX_W-1:0] + q_data.chroma_ofs;

        yl  = q_data.write_top ? q_data.luma_left  : '0;
        yr  = q_data.write_top ? q_data.luma_right : '0;
        u   = q_data.write_top ? q_data.chroma_u   : '0;
        v   = q_data.write_top ? q_data.chroma_v   : '0;
        ylb = q_data.write_below ? q_data.luma_left_below  : '0;
        yrb = q_data.write_below ? q_data.luma_right_below : '0;

        data_next = {5'b0, yrb, ylb, v, u, yr, yl,
                     q_data.write_top ? cidx : '0,
                     q_data.write_top ? lidx : '0};
        user_next = {q_data.write_below, q_data.write_top};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= q_data.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    a_below_needs_top: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && user_reg[1] |-> user_reg[0])
        else $error("lower pair written without top pair");

    a_skip_zero_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !user_reg[0] |-> data_reg[42:0] == '0)
        else $error("indices not cleared on skipped item");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking bench for color_key_overlay_compositor: streams overlay pixel pairs,
// predicts every frame write command and compares them on the result stream
// depends on ckoc_pkg and the compositor rtl in hdl/
`timescale 1ns / 1ps

module testbench;

    import ckoc_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_H       = DEF_MAX_HEIGHT;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 600000;

    // s_tdata layout, lowest bits first: yl, u, yr, v, yl_below, yr_below
    typedef struct packed {
        pixel_t yr_below;
        pixel_t yl_below;
        pixel_t v;
        pixel_t yr;
        pixel_t u;
        pixel_t yl;
    } pixel_pair_t;

    typedef struct packed {
        logic                  write_top;
        logic                  write_below;
        logic [LUMA_IDX_W-1:0] luma_index;
        logic [CHR_IDX_W-1:0]  chroma_index;
        pixel_t                yl;
        pixel_t                yr;
        pixel_t                u;
        pixel_t                v;
        pixel_t                yl_below;
        pixel_t                yr_below;
        logic                  last;
    } write_cmd_t;

    class write_cmd_tracker;
        logic [CFG_W-1:0] frame_width, frame_height, overlay_width, overlay_height;
        logic [POS_W-1:0] pos_x, pos_y;
        pixel_t           key;
        logic             mode_420;

        int unsigned column_count, row_count, luma_row_base, chroma_row_base;

        write_cmd_t pending_writes[$];
        int mismatches, n_pairs, n_written, n_below, n_overlay_ends;

        function new();
            frame_width     = RST_FRAME_WIDTH;
            frame_height    = RST_FRAME_HEIGHT;
            pos_x           = RST_POS_X;
            pos_y           = RST_POS_Y;
            overlay_width   = RST_OVERLAY_WIDTH;
            overlay_height  = RST_OVERLAY_HEIGHT;
            key             = RST_KEY;
            mode_420        = RST_CHROMA_MODE;
            column_count    = 0;
            row_count       = 0;
            luma_row_base   = 0;
            chroma_row_base = 0;
            mismatches      = 0;
            n_pairs         = 0;
            n_written       = 0;
            n_below         = 0;
            n_overlay_ends  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:    frame_width = val;
                REG_FRAME_HEIGHT:   frame_height = val;
                REG_POS_X:          pos_x = val[POS_W-1:0];
                REG_POS_Y:          pos_y = val[POS_W-1:0];
                REG_OVERLAY_WIDTH:  overlay_width = val;
                REG_OVERLAY_HEIGHT: overlay_height = val;
                REG_KEY:            key = val[PIX_W-1:0];
                REG_CHROMA_MODE:    mode_420 = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned sat(int unsigned v, int unsigned lim);
            return (v > lim) ? lim : v;
        endfunction

        function void note_pair(pixel_pair_t p);
            int unsigned fw, fh, ow, oh, stp, px, py, col, row, fx, fy, lorig, corig;
            bit top, below, row_end, ends;
            write_cmd_t e;
            fw  = sat(frame_width, MAX_W);
            fh  = sat(frame_height, MAX_H);
            ow  = sat(overlay_width, MAX_W);
            oh  = sat(overlay_height, MAX_H);
            stp = mode_420 ? 2 : 1;
            px  = pos_x & ~32'd1;
            py  = pos_y & ~32'd1;
            col = column_count * 2;
            row = row_count;
            fx  = px + col;
            fy  = py + row;
            top   = (fx + 1 < fw) && (fy < fh) && (p.yl != key);
            below = mode_420 && top && (fy + 1 < fh) && (row + 1 < oh);
            lorig = py * fw + px;
            // 4:2:0 chroma plane is a quarter of luma, 4:2:2 a half
            corig = mode_420 ? ((py * fw) >> 2) + (px >> 1) : (lorig >> 1);
            row_end = (col + 2 >= ow);
            ends    = row_end && (row + stp >= oh);

            e = '0;
            if (top) begin
                e.write_top    = 1'b1;
                e.luma_index   = LUMA_IDX_W'(lorig + luma_row_base + col);
                e.chroma_index = CHR_IDX_W'(corig + chroma_row_base + (col >> 1));
                e.yl = p.yl;
                e.yr = p.yr;
                e.u  = p.u;
                e.v  = p.v;
            end
            if (below) begin
                e.write_below = 1'b1;
                e.yl_below    = p.yl_below;
                e.yr_below    = p.yr_below;
            end
            e.last = ends;
            pending_writes.push_back(e);
            n_pairs++;
            n_written += top;
            n_below += below;
            n_overlay_ends += ends;

            if (!row_end) begin
                column_count++;
            end else begin
                column_count = 0;
                if (ends) begin
                    row_count       = 0;
                    luma_row_base   = 0;
                    chroma_row_base = 0;
                end else begin
                    row_count       = row + stp;
                    luma_row_base   = (luma_row_base + fw * stp) & 32'h3F_FFFF;
                    chroma_row_base = (chroma_row_base + (fw >> 1)) & 32'h1F_FFFF;
                end
            end
        endfunction

        function string fmt(write_cmd_t c);
            return $sformatf("top=%0d below=%0d luma=%0d chroma=%0d y=%h/%h u=%h v=%h yb=%h/%h last=%0d",
                c.write_top, c.write_below, c.luma_index, c.chroma_index, c.yl, c.yr,
                c.u, c.v, c.yl_below, c.yr_below, c.last);
        endfunction

        function void check_write(write_cmd_t got, logic [4:0] fill);
            write_cmd_t e;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: write command with none expected: %s", fmt(got));
                return;
            end
            e = pending_writes.pop_front();
            if (got !== e || fill !== 5'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("error: write command mismatch (fill %h)", fill);
                    $display("  expected %s", fmt(e));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // yl, u, yr, v, yl_below, yr_below
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // luma_index, chroma_index, yl, yr, u, v, yl_below, yr_below, zero fill
    logic [M_TDATA_W-1:0] m_tdata;
    // write_top, write_below
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    write_cmd_tracker tracker = new();
    int cycles   = 0;
    int settings = 0;

    color_key_overlay_compositor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycles, tracker.pending());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic pixel_pair_t mk_pair(int yl, int u, int yr, int v, int ylb, int yrb);
        pixel_pair_t p;
        p.yl       = PIX_W'(yl);
        p.u        = PIX_W'(u);
        p.yr       = PIX_W'(yr);
        p.v        = PIX_W'(v);
        p.yl_below = PIX_W'(ylb);
        p.yr_below = PIX_W'(yrb);
        return p;
    endfunction

    // a quarter of the pairs carry the key so transparency shows up often
    function automatic pixel_pair_t rand_pair();
        pixel_pair_t p;
        p = pixel_pair_t'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            p.yl = tracker.key;
        return p;
    endfunction

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        tracker.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic program_regs(int fw, int fh, int px, int py, int ow, int oh, int key,
                                int mode);
        set_reg(REG_FRAME_WIDTH, CFG_W'(fw));
        set_reg(REG_FRAME_HEIGHT, CFG_W'(fh));
        set_reg(REG_POS_X, CFG_W'(px));
        set_reg(REG_POS_Y, CFG_W'(py));
        set_reg(REG_OVERLAY_WIDTH, CFG_W'(ow));
        set_reg(REG_OVERLAY_HEIGHT, CFG_W'(oh));
        set_reg(REG_KEY, CFG_W'(key));
        set_reg(REG_CHROMA_MODE, CFG_W'(mode));
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // valid stays high across back-to-back items, dropped only for a gap
    task automatic send_pair(pixel_pair_t p, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_pair(p);
    endtask

    task automatic end_run();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // result side, with its own bursts of no stalling
    initial begin
        int gap;
        int left;
        bit burst;
        write_cmd_t got;
        left  = 0;
        burst = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (left == 0) begin
                burst = ($urandom_range(0, 3) == 0);
                left  = $urandom_range(10, 60);
            end
            left--;
            gap = burst ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.write_top    = m_tuser[0];
            got.write_below  = m_tuser[1];
            got.luma_index   = m_tdata[21:0];
            got.chroma_index = m_tdata[42:22];
            got.yl           = m_tdata[50:43];
            got.yr           = m_tdata[58:51];
            got.u            = m_tdata[66:59];
            got.v            = m_tdata[74:67];
            got.yl_below     = m_tdata[82:75];
            got.yr_below     = m_tdata[90:83];
            got.last         = m_tlast;
            tracker.check_write(got, m_tdata[95:91]);
        end
    end

    initial begin
        int fw, fh, px, py, ow, oh, stp, pairs, rows, total, count;
        bit burst;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: 2x1 overlay at the origin, key 0
        send_pair(mk_pair(0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a), 1'b0);
        send_pair(mk_pair(255, 255, 255, 255, 255, 255), 1'b1);
        send_pair(mk_pair(1, 0, 0, 0, 0, 0), 1'b0);
        end_run();

        // 4:2:0 at the bottom right corner: pairs and rows past the frame edge are clipped
        program_regs(16, 16, 13, 15, 6, 4, 8'h80, 1);
        send_pair(mk_pair(8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60), 1'b0);
        send_pair(mk_pair(8'h80, 8'h21, 8'h31, 8'h41, 8'h51, 8'h61), 1'b1);
        send_pair(mk_pair(8'hff, 8'h22, 8'h32, 8'h42, 8'h52, 8'h62), 1'b1);
        send_pair(mk_pair(8'h7f, 8'h23, 8'h33, 8'h43, 8'h53, 8'h63), 1'b0);
        send_pair(mk_pair(8'h00, 8'h24, 8'h34, 8'h44, 8'h54, 8'h64), 1'b0);
        send_pair(mk_pair(8'h81, 8'h25, 8'h35, 8'h45, 8'h55, 8'h65), 1'b0);
        end_run();

        // odd overlay width and height in 4:2:0: lower row beyond the overlay
        program_regs(64, 64, 0, 0, 3, 3, 8'h00, 1);
        repeat (4) send_pair(rand_pair(), 1'b0);
        end_run();

        // oversized frame saturates, zero overlay size makes every pair the last
        program_regs(4095, 4095, 2047, 2047, 0, 0, 8'h11, 0);
        send_pair(mk_pair(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55), 1'b0);
        send_pair(mk_pair(8'h11, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa), 1'b0);
        end_run();

        // largest frame and overlay, 4:2:0 at the far corner
        program_regs(2048, 2048, 2046, 2046, 4095, 4095, 8'hff, 1);
        repeat (4) send_pair(rand_pair(), 1'b1);
        end_run();

        while (tracker.n_pairs < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       fw = $urandom_range(0, 4095);
                1:       fw = MAX_W;
                default: fw = 2 * $urandom_range(8, 48);
            endcase
            case ($urandom_range(0, 9))
                0:       fh = $urandom_range(0, 4095);
                1:       fh = 16;
                default: fh = $urandom_range(16, 96);
            endcase
            px = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, (fw % 2048) + 8);
            py = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                             : $urandom_range(0, (fh % 2048) + 8);
            ow = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 24);
            oh = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
            program_regs(fw, fh, px, py, ow, oh, $urandom_range(0, 4095),
                         $urandom_range(0, 4095));

            // mostly whole overlays, sometimes a run cut short
            stp   = tracker.mode_420 ? 2 : 1;
            ow    = tracker.sat(ow, MAX_W);
            oh    = tracker.sat(oh, MAX_H);
            pairs = (ow <= 2) ? 1 : (ow + 1) / 2;
            rows  = (oh == 0) ? 1 : (oh + stp - 1) / stp;
            total = pairs * rows;
            if (total <= 96 && $urandom_range(0, 7) != 0)
                count = total * $urandom_range(1, 2);
            else
                count = $urandom_range(1, 40);

            burst = ($urandom_range(0, 3) == 0);
            repeat (count) send_pair(rand_pair(), burst);
            end_run();
        end

        repeat (8) @(posedge aclk);
        $display("%0d pairs over %0d settings: %0d written, %0d with lower pair, %0d overlay ends",
                 tracker.n_pairs, settings, tracker.n_written, tracker.n_below,
                 tracker.n_overlay_ends);
        $display("%0d mismatches in %0d cycles", tracker.mismatches, cycles);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ckoc_pkg.sv
hdl/ckoc_front.sv
hdl/ckoc_queue.sv
hdl/ckoc_back.sv
hdl/color_key_overlay_compositor.sv
test/testbench.sv
